// ===== hw/rtl/assert_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked concurrent checks used in the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/crcfp_pkg.sv =====
//------------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC step function of the frame parser.
//------------------------------------------------------------------------------
package crcfp_pkg;

  localparam int FRAME_BUFFER_BYTES_DEFAULT = 64;
  localparam int MIN_FRAME_BYTES            = 8;
  localparam int JOB_QUEUE_DEPTH            = 2;

  // Byte positions inside a frame.
  localparam int SYNC1_POS      = 0;
  localparam int SYNC2_POS      = 1;
  localparam int ID_HI_POS      = 2;
  localparam int ID_LO_POS      = 3;
  localparam int CMD_POS        = 4;
  localparam int PAYLOAD_OFFSET = 5;
  // The CRC is folded two bytes behind the newest one, from the id onward.
  localparam int CRC_START      = 4;

  // Wide enough for any payload length the buffer can hold.
  localparam int JOB_SIZE_W = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_TERMINATOR  = 2'd2;
  localparam logic [1:0] CFG_ADMIN_ID    = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_MSG  = 2'd1,
    STATUS_BAD_USER = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  terminator;
    logic [15:0] admin_id;
  } cfg_t;

  // One finished frame handed from the front to the back.
  typedef struct packed {
    status_e               status;
    logic [15:0]           user_id;
    logic [7:0]            command;
    logic [JOB_SIZE_W-1:0] size;
  } job_t;

  // CRC-16-CCITT, MSB first, one byte folded in.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crcfp_if.sv =====
//------------------------------------------------------------------------------
// crcfp interfaces
// Valid/ready channels for received bytes, results and register writes.
//------------------------------------------------------------------------------
interface crcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] user_id;
  logic [7:0]  command;
  logic [5:0]  payload_len;
  logic        is_payload;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output status, output user_id, output command,
                  output payload_len, output is_payload, output payload_byte,
                  output last, input ready);
  modport sink (input valid, input status, input user_id, input command,
                input payload_len, input is_payload, input payload_byte,
                input last, output ready);
endinterface

interface crcfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/crcfp_ram.sv =====
//------------------------------------------------------------------------------
// crcfp_ram
// Generic single-write, single-read RAM with a registered read port.
//------------------------------------------------------------------------------
module crcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/crcfp_fifo.sv =====
//------------------------------------------------------------------------------
// crcfp_fifo
// Short job queue between the frame front end and the result back end.
//------------------------------------------------------------------------------
module crcfp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crcfp_pkg::job_t   push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output crcfp_pkg::job_t   pop_job_o,
  output logic              empty_o
);
  import crcfp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] fill_q, fill_d;

  assign full_o    = (fill_q == CW'(DEPTH));
  assign empty_o   = (fill_q == '0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== hw/rtl/crcfp_front.sv =====
//------------------------------------------------------------------------------
// crcfp_front
// Accepts received bytes, tracks the frame and classifies it at the terminator.
//------------------------------------------------------------------------------
module crcfp_front #(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  crcfp_pkg::cfg_t                       cfg_i,
  crcfp_rx_if.sink                              rx_i,
  input  logic                                  mem_busy_i,
  input  logic                                  queue_full_i,
  output logic                                  push_o,
  output crcfp_pkg::job_t                       job_o,
  output logic                                  ram_we_o,
  output logic [$clog2(FRAME_BUFFER_BYTES)-1:0] ram_waddr_o,
  output logic [7:0]                            ram_wdata_o
);
  import crcfp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int AW    = $clog2(FRAME_BUFFER_BYTES);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       prev1_q, prev2_q;
  logic [7:0]       sync1_q, sync2_q, id_hi_q, id_lo_q, cmd_q;

  logic is_term, buf_full, stores_mem, accept;
  logic len_bad, msg_bad, user_bad;

  assign is_term    = (rx_i.rx_byte == cfg_i.terminator);
  assign buf_full   = (count_q == CNT_W'(FRAME_BUFFER_BYTES));
  assign stores_mem = !is_term && !buf_full && (count_q >= CNT_W'(PAYLOAD_OFFSET));

  // Bytes that land in the buffer wait while the back end still reads it.
  assign rx_i.ready = is_term ? !queue_full_i : !(stores_mem && mem_busy_i);
  assign accept     = rx_i.valid && rx_i.ready;

  assign ram_we_o    = accept && stores_mem;
  assign ram_waddr_o = AW'(count_q);
  assign ram_wdata_o = rx_i.rx_byte;

  assign len_bad  = ovf_q || buf_full || (count_q < CNT_W'(MIN_FRAME_BYTES - 1));
  assign msg_bad  = len_bad || ({prev1_q, prev2_q} != crc_q) ||
                    (sync1_q != cfg_i.sync_first) || (sync2_q != cfg_i.sync_second);
  assign user_bad = ({id_hi_q, id_lo_q} != cfg_i.admin_id);

  assign push_o = accept && is_term;

  always_comb begin
    job_o = '{status: STATUS_OK, user_id: {id_hi_q, id_lo_q}, command: cmd_q,
              size: JOB_SIZE_W'(count_q - CNT_W'(MIN_FRAME_BYTES - 1))};
    if (msg_bad) begin
      job_o = '{status: STATUS_BAD_MSG, user_id: '0, command: '0, size: '0};
    end else if (user_bad) begin
      job_o.status  = STATUS_BAD_USER;
      job_o.command = '0;
      job_o.size    = '0;
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    crc_d   = crc_q;
    if (accept && is_term) begin
      count_d = '0;
      ovf_d   = 1'b0;
      crc_d   = CRC_INIT;
    end else if (accept) begin
      if (buf_full) begin
        ovf_d = 1'b1;
      end else begin
        if (count_q >= CNT_W'(CRC_START)) begin
          crc_d = crc16_fold(crc_q, prev2_q);
        end
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      crc_q   <= CRC_INIT;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      crc_q   <= crc_d;
    end
  end

  // Header bytes and the two newest bytes are kept in registers.
  always_ff @(posedge clk_i) begin
    if (accept && !is_term && !buf_full) begin
      prev1_q <= rx_i.rx_byte;
      prev2_q <= prev1_q;
      case (count_q)
        CNT_W'(SYNC1_POS): sync1_q <= rx_i.rx_byte;
        CNT_W'(SYNC2_POS): sync2_q <= rx_i.rx_byte;
        CNT_W'(ID_HI_POS): id_hi_q <= rx_i.rx_byte;
        CNT_W'(ID_LO_POS): id_lo_q <= rx_i.rx_byte;
        CNT_W'(CMD_POS):   cmd_q   <= rx_i.rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/crcfp_back.sv =====
//------------------------------------------------------------------------------
// crcfp_back
// Turns queued jobs into a status word and the payload words of a good frame.
//------------------------------------------------------------------------------
module crcfp_back #(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  queue_empty_i,
  input  crcfp_pkg::job_t                       queue_job_i,
  output logic                                  pop_o,
  output logic                                  busy_o,
  output logic [$clog2(FRAME_BUFFER_BYTES)-1:0] ram_raddr_o,
  input  logic [7:0]                            ram_rdata_i,
  crcfp_res_if.source                           res_o
);
  import crcfp_pkg::*;

  localparam int AW = $clog2(FRAME_BUFFER_BYTES);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_PAY  = 2'b10
  } back_state_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] user_id;
    logic [7:0]  command;
    logic [5:0]  payload_len;
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  back_state_e           state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;
  job_t                  job_q, job_d;
  logic [JOB_SIZE_W-1:0] idx_q, idx_d;
  logic                  rdv_q, rdv_d;
  logic                  slot_free, is_last;

  assign slot_free   = !out_valid_q || res_o.ready;
  assign is_last     = (idx_q + JOB_SIZE_W'(1) == job_q.size);
  assign busy_o      = (state_q == BK_PAY);
  assign ram_raddr_o = AW'({1'b0, idx_q} + (JOB_SIZE_W + 1)'(PAYLOAD_OFFSET));

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !res_o.ready;
    res_d       = res_q;
    job_d       = job_q;
    idx_d       = idx_q;
    rdv_d       = rdv_q;
    pop_o       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!queue_empty_i && slot_free) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          res_d       = '{status: queue_job_i.status, user_id: queue_job_i.user_id,
                          command: queue_job_i.command,
                          payload_len: 6'(queue_job_i.size), is_payload: 1'b0,
                          payload_byte: '0, last: (queue_job_i.size == '0)};
          job_d       = queue_job_i;
          idx_d       = '0;
          rdv_d       = 1'b0;
          if (queue_job_i.size != '0) begin
            state_d = BK_PAY;
          end
        end
      end
      BK_PAY: begin
        // Once rdv_q is set, the registered read of the current address is valid.
        rdv_d = 1'b1;
        if (rdv_q && slot_free) begin
          out_valid_d        = 1'b1;
          res_d.is_payload   = 1'b1;
          res_d.payload_byte = ram_rdata_i;
          res_d.last         = is_last;
          idx_d              = idx_q + JOB_SIZE_W'(1);
          rdv_d              = 1'b0;
          if (is_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      rdv_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rdv_q       <= rdv_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    job_q <= job_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.user_id      = res_q.user_id;
  assign res_o.command      = res_q.command;
  assign res_o.payload_len  = res_q.payload_len;
  assign res_o.is_payload   = res_q.is_payload;
  assign res_o.payload_byte = res_q.payload_byte;
  assign res_o.last         = res_q.last;

endmodule

// ===== hw/rtl/crc_checked_frame_parser_core.sv =====
//------------------------------------------------------------------------------
// crc_checked_frame_parser_core
// Byte-stream frame parser with sync, CRC-16-CCITT and sender id checks.
//------------------------------------------------------------------------------
// Usage: received bytes enter on rx_i, one word per handshake. Every byte that
// is not the terminator value is held (dropped once the buffer is full) and
// nothing comes out. The terminator ends the frame: one status word leaves on
// res_o, and when the frame is good its payload bytes follow as further words,
// the final word of the frame carrying last. Registers (sync bytes, terminator,
// admin id) are written through cfg_i, which is always ready; write them only
// while idle. Header bytes are taken every cycle. The status word passes
// through the job queue and the output register after the terminator is
// taken. Payload words follow one at a time, each through the registered
// read of the frame buffer and then the output register. Up to two finished
// frames wait in the job queue. Bytes bound for the frame buffer wait while
// an earlier frame is queued or still being read out; a terminator waits
// only when the job queue is full. When the receiver stalls, the output word
// holds and the back end stops. Reset clears the frame count, overflow flag,
// CRC, registers, queue and output valid. The frame buffer needs no clearing:
// only bytes of the current frame are read.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module crc_checked_frame_parser_core #(
  parameter int FRAME_BUFFER_BYTES = crcfp_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfp_rx_if.sink    rx_i,
  crcfp_res_if.source res_o,
  crcfp_cfg_if.sink   cfg_i
);
  import crcfp_pkg::*;

  localparam int AW = $clog2(FRAME_BUFFER_BYTES);

  cfg_t          cfg_q, cfg_d;
  job_t          push_job, pop_job;
  logic          job_push, job_pop, queue_full, queue_empty;
  logic          back_busy, mem_busy;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_SYNC_FIRST:  cfg_d.sync_first  = cfg_i.wdata[7:0];
        CFG_SYNC_SECOND: cfg_d.sync_second = cfg_i.wdata[7:0];
        CFG_TERMINATOR:  cfg_d.terminator  = cfg_i.wdata[7:0];
        CFG_ADMIN_ID:    cfg_d.admin_id    = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The buffer is in use while any queued or active frame may still read it.
  assign mem_busy = !queue_empty || back_busy;

  crcfp_front #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rx_i        (rx_i),
    .mem_busy_i  (mem_busy),
    .queue_full_i(queue_full),
    .push_o      (job_push),
    .job_o       (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  crcfp_fifo #(
    .DEPTH(JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (job_push),
    .push_job_i(push_job),
    .full_o    (queue_full),
    .pop_i     (job_pop),
    .pop_job_o (pop_job),
    .empty_o   (queue_empty)
  );

  crcfp_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BUFFER_BYTES)
  ) u_frame_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  crcfp_back #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(queue_empty),
    .queue_job_i  (pop_job),
    .pop_o        (job_pop),
    .busy_o       (back_busy),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .res_o        (res_o)
  );

  // The front end never overwrites the buffer while payload is pending.
  `ASSERT_IMPLIES(a_no_buf_write_busy, clk_i, rst_ni, ram_we, !mem_busy)
  // A terminator is only taken when the queue has room.
  `ASSERT_IMPLIES(a_no_queue_overflow, clk_i, rst_ni, job_push, !queue_full)
  // A rejected frame yields exactly one word, so it is marked last.
  `ASSERT_IMPLIES(a_reject_is_last, clk_i, rst_ni,
                  res_o.valid && (res_o.status != STATUS_OK), res_o.last)
  // Payload words only follow a good frame.
  `ASSERT_IMPLIES(a_payload_ok, clk_i, rst_ni,
                  res_o.valid && res_o.is_payload, res_o.status == STATUS_OK)
  // A rejected job never starts a payload readout.
  `ASSERT_NEXT(a_reject_no_readout, clk_i, rst_ni,
               job_pop && (pop_job.status != STATUS_OK), !back_busy)

endmodule

// ===== sim/crc_frame_checker.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// crc_frame_checker
// Watches the byte, result and register channels of the frame parser. It keeps
// its own copy of the frame state and registers, works out the words each
// accepted byte must cause, and compares every result word with them in order.
//------------------------------------------------------------------------------
module crc_frame_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  crcfp_rx_if   rx_mon,
  crcfp_res_if  res_mon,
  crcfp_cfg_if  cfg_mon,
  output int    fail_count_o,
  output int    pending_o
);
  import crcfp_pkg::*;

  localparam int STORE_BYTES = FRAME_BUFFER_BYTES_DEFAULT;

  typedef struct packed {
    status_e     status;
    logic [15:0] user_id;
    logic [7:0]  command;
    logic [5:0]  payload_len;
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic        last;
  } res_word_t;

  res_word_t   pending_words[$];
  logic [7:0]  frame_bytes[STORE_BYTES];
  int unsigned held_count;
  logic        lost_bytes;
  logic [15:0] running_crc;
  cfg_t        regs;
  int          fails = 0;

  // CRC-16-CCITT, one input bit at a time, most significant bit first.
  function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    int unsigned flen;
    logic [15:0] sent_crc;
    logic [15:0] uid;
    logic [5:0]  psize;
    res_word_t   w;
    if (b != regs.terminator) begin
      if (held_count >= STORE_BYTES) begin
        lost_bytes = 1'b1;
      end else begin
        // The CRC trails the newest byte by two, so the CRC bytes never enter it.
        if (held_count >= CRC_START) begin
          running_crc = ccitt_next(running_crc, frame_bytes[held_count - 2]);
        end
        frame_bytes[held_count] = b;
        held_count++;
      end
      return;
    end
    flen   = held_count + 1;
    w      = '0;
    w.last = 1'b1;
    w.status = STATUS_BAD_MSG;
    if (lost_bytes || flen > STORE_BYTES || flen < MIN_FRAME_BYTES) begin
      pending_words.push_back(w);
    end else begin
      sent_crc = {frame_bytes[held_count - 1], frame_bytes[held_count - 2]};
      uid      = {frame_bytes[ID_HI_POS], frame_bytes[ID_LO_POS]};
      if (sent_crc != running_crc || frame_bytes[SYNC1_POS] != regs.sync_first ||
          frame_bytes[SYNC2_POS] != regs.sync_second) begin
        pending_words.push_back(w);
      end else if (uid != regs.admin_id) begin
        w.status  = STATUS_BAD_USER;
        w.user_id = uid;
        pending_words.push_back(w);
      end else begin
        psize          = 6'(flen - MIN_FRAME_BYTES);
        w.status       = STATUS_OK;
        w.user_id      = uid;
        w.command      = frame_bytes[CMD_POS];
        w.payload_len  = psize;
        w.last         = (psize == 0);
        pending_words.push_back(w);
        w.is_payload = 1'b1;
        for (int i = 0; i < psize; i++) begin
          w.payload_byte = frame_bytes[PAYLOAD_OFFSET + i];
          w.last         = (i + 1 == psize);
          pending_words.push_back(w);
        end
      end
    end
    held_count  = 0;
    lost_bytes  = 1'b0;
    running_crc = CRC_INIT;
  endtask

  task automatic note_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  task automatic check_word(input res_word_t a);
    res_word_t e;
    if (pending_words.size() == 0) begin
      fails++;
      $display("%0t: unexpected word, expected nothing, got %p", $time, a);
      return;
    end
    e = pending_words.pop_front();
    note_field("status", 16'(e.status), 16'(a.status));
    note_field("user_id", e.user_id, a.user_id);
    note_field("command", 16'(e.command), 16'(a.command));
    note_field("payload_len", 16'(e.payload_len), 16'(a.payload_len));
    note_field("is_payload", 16'(e.is_payload), 16'(a.is_payload));
    note_field("payload_byte", 16'(e.payload_byte), 16'(a.payload_byte));
    note_field("last", 16'(e.last), 16'(a.last));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_count  = 0;
      lost_bytes  = 1'b0;
      running_crc = CRC_INIT;
      regs        = '0;
      pending_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          CFG_SYNC_FIRST:  regs.sync_first  = cfg_mon.wdata[7:0];
          CFG_SYNC_SECOND: regs.sync_second = cfg_mon.wdata[7:0];
          CFG_TERMINATOR:  regs.terminator  = cfg_mon.wdata[7:0];
          CFG_ADMIN_ID:    regs.admin_id    = cfg_mon.wdata;
          default: ;
        endcase
      end
      if (rx_mon.valid && rx_mon.ready) begin
        parse_rx_byte(rx_mon.rx_byte);
      end
      if (res_mon.valid && res_mon.ready) begin
        check_word('{status_e'(res_mon.status), res_mon.user_id, res_mon.command,
                     res_mon.payload_len, res_mon.is_payload, res_mon.payload_byte,
                     res_mon.last});
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_words.size();
  end

endmodule

// ===== sim/crc_checked_frame_parser_core_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// crc_checked_frame_parser_core_tb
// Builds framed byte streams for the parser, good and broken, under several
// register settings, with random gaps on both sides and one long receiver
// hold. A checker beside the block predicts and compares every result word.
//------------------------------------------------------------------------------
module crc_checked_frame_parser_core_tb;
  import crcfp_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the deliberate receiver hold below plus
  // random gaps, so this leaves a wide margin.
  localparam int QUIET_LIMIT      = 3000;
  // Cycles allowed after the last expected word, so that bytes still parked
  // behind a payload readout have landed before registers change.
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int IDLE_PCT         = 11;
  // Largest payload that still fits the frame buffer with header, CRC and
  // terminator.
  localparam int MAX_PAYLOAD      = FRAME_BUFFER_BYTES_DEFAULT - MIN_FRAME_BYTES;
  localparam int RANDOM_PHASES    = 2;
  localparam int FRAMES_PER_PHASE = 3;

  // Shapes of frame the stimulus can build.
  typedef enum int {
    KIND_GOOD,
    KIND_BAD_USER,
    KIND_BAD_CRC,
    KIND_BAD_SYNC,
    KIND_JUNK
  } frame_kind_e;

  logic clk_i;
  logic rst_ni;

  crcfp_rx_if  rx();
  crcfp_res_if res();
  crcfp_cfg_if cfg();

  int   fail_count;
  int   pending;
  int   idle_pct;
  logic hold_req;
  logic hold_served = 1'b0;
  int   quiet_cycles = 0;
  cfg_t cur;

  crc_checked_frame_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  crc_frame_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_mon       (rx),
    .res_mon      (res),
    .cfg_mon      (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx.valid && rx.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver. It drops ready at random, and once, on request, holds it
  // low for a long stretch so that the block fills and the byte input backs
  // up while the sender keeps offering.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_served) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_served = 1'b1;
      end else begin
        res.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offers one byte, with random gaps before it, and returns at the edge on
  // which it is taken. Valid is left high so that back-to-back bytes flow.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk_i);
    while (!rx.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  // The byte registers get random upper data bits; only the low byte counts.
  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] tm, input logic [15:0] adm);
    write_reg(CFG_SYNC_FIRST, {8'($urandom), sf});
    write_reg(CFG_SYNC_SECOND, {8'($urandom), ss});
    write_reg(CFG_TERMINATOR, {8'($urandom), tm});
    write_reg(CFG_ADMIN_ID, adm);
    cfg.valid <= 1'b0;
    cur = '{sync_first: sf, sync_second: ss, terminator: tm, admin_id: adm};
  endtask

  // Any byte value except the current terminator.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    do begin
      v = 8'($urandom);
    end while (v == cur.terminator);
    return v;
  endfunction

  // Stops offering and waits until every expected word has been taken, then
  // lets the block settle. The first edge makes the newest prediction visible.
  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Builds one frame under the current registers and sends it, terminator
  // included. For the framed kinds plen is the payload length, which may run
  // past the buffer to provoke the too-long and overflow cases. For junk it is
  // the number of stray bytes before the terminator.
  task automatic send_frame(input frame_kind_e kind, input int plen);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [15:0] uid;
    logic [7:0]  crc_lo;
    if (kind == KIND_JUNK) begin
      repeat (plen) body.push_back(pick_byte());
    end else begin
      if (kind == KIND_BAD_USER) begin
        do begin
          uid = {pick_byte(), pick_byte()};
        end while (uid == cur.admin_id);
      end else begin
        uid = cur.admin_id;
      end
      // Redraw the content until neither CRC byte collides with the
      // terminator, which would cut the frame short.
      do begin
        body.delete();
        body.push_back(cur.sync_first);
        body.push_back(cur.sync_second);
        body.push_back(uid[15:8]);
        body.push_back(uid[7:0]);
        body.push_back(pick_byte());
        repeat (plen) body.push_back(pick_byte());
        crc = CRC_INIT;
        for (int i = ID_HI_POS; i < body.size(); i++) crc = crc16_fold(crc, body[i]);
      end while (crc[7:0] == cur.terminator || crc[15:8] == cur.terminator);
      crc_lo = crc[7:0];
      if (kind == KIND_BAD_CRC) begin
        crc_lo = crc[7:0] ^ 8'h01;
        if (crc_lo == cur.terminator) crc_lo = crc[7:0] ^ 8'h02;
      end
      if (kind == KIND_BAD_SYNC) begin
        // Sync bytes sit outside the CRC, so only the sync check can fail.
        if ($urandom_range(1) == 0) begin
          do body[SYNC1_POS] = pick_byte(); while (body[SYNC1_POS] == cur.sync_first);
        end else begin
          do body[SYNC2_POS] = pick_byte(); while (body[SYNC2_POS] == cur.sync_second);
        end
      end
      body.push_back(crc_lo);
      body.push_back(crc[15:8]);
    end
    foreach (body[i]) push_byte(body[i]);
    push_byte(cur.terminator);
  endtask

  initial begin
    frame_kind_e kind;
    int          plen;
    int          roll;
    logic [7:0]  tm;
    rst_ni        <= 1'b0;
    rx.valid      <= 1'b0;
    rx.rx_byte    <= 8'h00;
    cfg.valid     <= 1'b0;
    cfg.reg_index <= CFG_SYNC_FIRST;
    cfg.wdata     <= 16'h0000;
    idle_pct      <= IDLE_PCT;
    hold_req      <= 1'b0;
    cur           = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset values the terminator is zero and so are both sync
    // bytes, so no frame can pass; a lone terminator and a truncated frame
    // must both come back as invalid messages.
    send_frame(KIND_JUNK, 0);
    send_frame(KIND_JUNK, 6);
    drain();

    // Directed part: every status, the empty payload, and a frame that
    // overruns the buffer so that a byte is lost, followed by a good frame
    // to show that the parser recovers.
    program_regs(8'hA5, 8'h5A, 8'h0D, 16'h1234);
    send_frame(KIND_GOOD, 0);
    send_frame(KIND_GOOD, 2);
    send_frame(KIND_BAD_CRC, 1);
    send_frame(KIND_BAD_SYNC, 0);
    send_frame(KIND_BAD_USER, 0);
    send_frame(KIND_JUNK, 4);
    send_frame(KIND_GOOD, MAX_PAYLOAD + 2);
    send_frame(KIND_GOOD, 1);
    drain();

    // Register extremes: zero first sync byte and admin id, all-ones terminator.
    program_regs(8'h00, 8'hFE, 8'hFF, 16'h0000);
    send_frame(KIND_GOOD, 2);
    send_frame(KIND_BAD_USER, 0);
    drain();

    // And the other way round: all-ones sync and admin id, zero terminator.
    program_regs(8'hFF, 8'hFF, 8'h00, 16'hFFFF);
    send_frame(KIND_GOOD, 1);
    send_frame(KIND_BAD_SYNC, 0);
    drain();

    // Random part. Each phase draws fresh registers whose sync and admin id
    // bytes avoid the terminator, so well-formed frames can be built.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tm = 8'($urandom);
      cur.terminator = tm;
      program_regs(pick_byte(), pick_byte(), tm, {pick_byte(), pick_byte()});
      // One phase runs with no gaps at all on either side.
      idle_pct <= (phase == 0) ? 0 : IDLE_PCT;
      // In the other the receiver goes quiet for a long time while the sender
      // keeps pushing payload-carrying frames into the block.
      if (phase == 1) hold_req <= 1'b1;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        roll = $urandom_range(99);
        if (phase == 1)    kind = KIND_GOOD;
        else if (roll < 60) kind = KIND_GOOD;
        else if (roll < 72) kind = KIND_BAD_USER;
        else if (roll < 80) kind = KIND_BAD_CRC;
        else if (roll < 88) kind = KIND_BAD_SYNC;
        else               kind = KIND_JUNK;
        // Mostly short payloads; now and then a longer one.
        roll = $urandom_range(99);
        if (phase == 1)     plen = $urandom_range(5, 2);
        else if (roll < 90) plen = $urandom_range(6);
        else                plen = $urandom_range(20, 7);
        send_frame(kind, plen);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
